/* hw/rtl/aging_neighbor_table_core_macros.svh */
// Assertion helpers used by the checker file.
`ifndef AGING_NEIGHBOR_TABLE_CORE_MACROS_SVH
`define AGING_NEIGHBOR_TABLE_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ANT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication.
`define ANT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`endif

/* hw/rtl/ant_pkg.sv */
package ant_pkg;

  localparam int unsigned ENTRIES   = 16;
  localparam int unsigned IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W     = $clog2(ENTRIES + 1);
  localparam int unsigned SERIAL_W  = 32;
  localparam int unsigned STAMP_W   = 16;
  localparam int unsigned OUT_CNT_W = 5;
  localparam int unsigned ENTRY_W   = SERIAL_W + STAMP_W;

  typedef enum logic [1:0] {
    KIND_HELLO  = 2'd0,
    KIND_AGE    = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_STATUS = 2'd3
  } kind_e;

endpackage

/* hw/rtl/ant_in_if.sv */
interface ant_in_if import ant_pkg::*;
  ;
  logic                valid;
  logic                ready;
  kind_e               kind;
  logic [SERIAL_W-1:0] serial;
  logic [STAMP_W-1:0]  now;

  modport source (output valid, kind, serial, now, input ready);
  modport sink   (input valid, kind, serial, now, output ready);
endinterface

/* hw/rtl/ant_out_if.sv */
interface ant_out_if import ant_pkg::*;
  ;
  logic                 valid;
  logic                 ready;
  logic [OUT_CNT_W-1:0] valid_count;
  logic                 hit;
  logic                 inserted;
  logic                 dropped;
  logic [OUT_CNT_W-1:0] removed;

  modport source (output valid, valid_count, hit, inserted, dropped, removed, input ready);
  modport sink   (input valid, valid_count, hit, inserted, dropped, removed, output ready);
endinterface

/* hw/rtl/ant_ram.sv */
module ant_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/aging_neighbor_table_core.sv */
// Neighbor table of ENTRIES serials, each with a 16-bit last-heard stamp, held
// in one single-port-read RAM; occupancy lives in per-entry valid flops. Items
// are handled one at a time. A hello with a nonzero serial and an age sweep
// walk the whole RAM, one read per cycle; clear, status and a hello with a
// zero serial go straight to the finish state. The finish state of an item
// waits while the output register still holds a result that has not been
// taken. A hello that hits rewrites the stamp; a miss takes the highest free
// index. The result sits in an output register, so the next item is taken
// while a result still waits. The user must write max_age only while idle;
// the block itself does not enforce it.
module aging_neighbor_table_core import ant_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               max_age_we_i,
  input  logic [STAMP_W-1:0] max_age_i,
  ant_in_if.sink             in_i,
  ant_out_if.source          out_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_WALK   = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  state_e state_q, state_d;

  logic [STAMP_W-1:0]  max_age_q;
  logic [ENTRIES-1:0]  valid_q, valid_d;
  logic [CNT_W-1:0]    count_q, count_d;

  kind_e               kind_q;
  logic [SERIAL_W-1:0] serial_q;
  logic [STAMP_W-1:0]  now_q;

  logic [IDX_W-1:0]    rd_idx_q, rd_idx_d;
  logic                issue_q, issue_d;
  logic                chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0]    chk_idx_q, chk_idx_d;

  logic                hit_q, hit_d;
  logic [IDX_W-1:0]    hit_idx_q, hit_idx_d;
  logic                free_q, free_d;
  logic [IDX_W-1:0]    free_idx_q, free_idx_d;
  logic [CNT_W-1:0]    removed_q, removed_d;

  logic                 out_valid_q, out_valid_d;
  logic [OUT_CNT_W-1:0] out_count_q, out_count_d;
  logic                 out_hit_q, out_hit_d;
  logic                 out_ins_q, out_ins_d;
  logic                 out_drop_q, out_drop_d;
  logic [OUT_CNT_W-1:0] out_rem_q, out_rem_d;

  logic                in_xfer;
  logic                out_free;
  logic                finish;
  logic                hello_act;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic [SERIAL_W-1:0] ent_serial;
  logic [STAMP_W-1:0]  ent_stamp;
  logic [STAMP_W-1:0]  ent_age;
  logic                ent_valid;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign finish     = (state_q == ST_FINISH) && out_free;
  assign hello_act  = (kind_q == KIND_HELLO) && (serial_q != '0);

  assign ent_serial = ram_rdata[ENTRY_W-1:STAMP_W];
  assign ent_stamp  = ram_rdata[STAMP_W-1:0];
  assign ent_age    = now_q - ent_stamp;
  assign ent_valid  = valid_q[chk_idx_q];

  // Stamp refresh on a hit, new entry on a miss with room.
  assign ram_we    = finish && hello_act && (hit_q || free_q);
  assign ram_waddr = hit_q ? hit_idx_q : free_idx_q;

  ant_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({serial_q, now_q}),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    issue_d     = issue_q;
    chk_vld_d   = 1'b0;
    chk_idx_d   = chk_idx_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    removed_d   = removed_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_count_d = out_count_q;
    out_hit_d   = out_hit_q;
    out_ins_d   = out_ins_q;
    out_drop_d  = out_drop_q;
    out_rem_d   = out_rem_q;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          rd_idx_d  = '0;
          hit_d     = 1'b0;
          free_d    = 1'b0;
          removed_d = '0;
          if ((in_i.kind == KIND_AGE) ||
              ((in_i.kind == KIND_HELLO) && (in_i.serial != '0))) begin
            issue_d = 1'b1;
            state_d = ST_WALK;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_WALK: begin
        // Read issued at rd_idx_q, checked in the next cycle at chk_idx_q.
        if (issue_q) begin
          chk_vld_d = 1'b1;
          chk_idx_d = rd_idx_q;
          if (rd_idx_q == LAST_IDX) begin
            issue_d = 1'b0;
          end else begin
            rd_idx_d = rd_idx_q + IDX_W'(1);
          end
        end
        if (chk_vld_q) begin
          if (kind_q == KIND_AGE) begin
            if (ent_valid && (ent_age >= max_age_q)) begin
              valid_d[chk_idx_q] = 1'b0;
              removed_d          = removed_q + CNT_W'(1);
            end
          end else begin
            if (ent_valid && (ent_serial == serial_q) && !hit_q) begin
              hit_d     = 1'b1;
              hit_idx_d = chk_idx_q;
            end
            if (!ent_valid) begin
              free_d     = 1'b1;
              free_idx_d = chk_idx_q;
            end
          end
          if (chk_idx_q == LAST_IDX) begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_hit_d  = 1'b0;
          out_ins_d  = 1'b0;
          out_drop_d = 1'b0;
          out_rem_d  = '0;
          case (kind_q)
            KIND_HELLO: begin
              if (hello_act) begin
                if (hit_q) begin
                  out_hit_d = 1'b1;
                end else if (free_q) begin
                  valid_d[free_idx_q] = 1'b1;
                  count_d             = count_q + CNT_W'(1);
                  out_ins_d           = 1'b1;
                end else begin
                  out_drop_d = 1'b1;
                end
              end
            end
            KIND_AGE: begin
              count_d   = count_q - removed_q;
              out_rem_d = OUT_CNT_W'(removed_q);
            end
            KIND_CLEAR: begin
              valid_d   = '0;
              count_d   = '0;
              out_rem_d = OUT_CNT_W'(count_q);
            end
            default: begin
            end
          endcase
          out_count_d = OUT_CNT_W'(count_d);
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      max_age_q   <= STAMP_W'(60);
      valid_q     <= '0;
      count_q     <= '0;
      issue_q     <= 1'b0;
      chk_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      removed_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (max_age_we_i) begin
        max_age_q <= max_age_i;
      end
      valid_q     <= valid_d;
      count_q     <= count_d;
      issue_q     <= issue_d;
      chk_vld_q   <= chk_vld_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      removed_q   <= removed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      kind_q   <= in_i.kind;
      serial_q <= in_i.serial;
      now_q    <= in_i.now;
    end
    rd_idx_q    <= rd_idx_d;
    chk_idx_q   <= chk_idx_d;
    hit_idx_q   <= hit_idx_d;
    free_idx_q  <= free_idx_d;
    out_count_q <= out_count_d;
    out_hit_q   <= out_hit_d;
    out_ins_q   <= out_ins_d;
    out_drop_q  <= out_drop_d;
    out_rem_q   <= out_rem_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.valid_count = out_count_q;
  assign out_o.hit         = out_hit_q;
  assign out_o.inserted    = out_ins_q;
  assign out_o.dropped     = out_drop_q;
  assign out_o.removed     = out_rem_q;

endmodule

/* hw/rtl/ant_checker.sv */
`include "aging_neighbor_table_core_macros.svh"

module ant_checker import ant_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic [OUT_CNT_W-1:0] out_valid_count_i,
  input logic                 out_hit_i,
  input logic                 out_inserted_i,
  input logic                 out_dropped_i,
  input logic [OUT_CNT_W-1:0] out_removed_i
);

  // One item in flight: ready drops right after a transfer.
  `ANT_ASSERT_NXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // A hello ends in exactly one of hit, insert or drop, or none for a zero serial.
  `ANT_ASSERT_IMP(a_hello_flags, clk_i, rst_ni, out_valid_i,
                  $onehot0({out_hit_i, out_inserted_i, out_dropped_i}))

  // Hello results never report removals.
  `ANT_ASSERT_IMP(a_hello_no_removed, clk_i, rst_ni,
                  out_valid_i && (out_hit_i || out_inserted_i || out_dropped_i),
                  out_removed_i == '0)

  // An insert leaves at least one occupied entry.
  `ANT_ASSERT_IMP(a_insert_count, clk_i, rst_ni, out_valid_i && out_inserted_i,
                  out_valid_count_i != '0)

endmodule

bind aging_neighbor_table_core ant_checker u_ant_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_valid_count_i (out_o.valid_count),
  .out_hit_i         (out_o.hit),
  .out_inserted_i    (out_o.inserted),
  .out_dropped_i     (out_o.dropped),
  .out_removed_i     (out_o.removed)
);

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import ant_pkg::*;

  typedef struct packed {
    kind_e               kind;
    logic [SERIAL_W-1:0] serial;
    logic [STAMP_W-1:0]  now;
  } hello_item_t;

  typedef struct packed {
    logic [OUT_CNT_W-1:0] valid_count;
    logic                 hit;
    logic                 inserted;
    logic                 dropped;
    logic [OUT_CNT_W-1:0] removed;
  } table_status_t;

  logic               clk_i;
  logic               rst_ni;
  logic               max_age_we_i;
  logic [STAMP_W-1:0] max_age_i;

  ant_in_if  in_if ();
  ant_out_if out_if ();

  aging_neighbor_table_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .max_age_we_i (max_age_we_i),
    .max_age_i    (max_age_i),
    .in_i         (in_if),
    .out_o        (out_if)
  );

  // predicted table contents
  logic [SERIAL_W-1:0] nbr_serial [ENTRIES];
  logic [STAMP_W-1:0]  nbr_stamp  [ENTRIES];
  int unsigned         nbr_count;
  logic [STAMP_W-1:0]  max_age_cfg;

  hello_item_t         pending_items [$];
  table_status_t       expected_status [$];
  logic [SERIAL_W-1:0] serial_pool [24];
  logic [STAMP_W-1:0]  stim_now;
  int unsigned         send_idle_pct;
  int unsigned         recv_stall_pct;
  int unsigned         fail_count;
  bit                  in_taken;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("[aging_neighbor_table_core] ERROR");
    $finish;
  end

  function automatic table_status_t update_table(hello_item_t it);
    table_status_t       r;
    int                  i;
    int                  slot;
    bit                  have_free;
    bit                  found;
    int unsigned         gone;
    logic [STAMP_W-1:0]  age;
    r         = '0;
    slot      = 0;
    have_free = 1'b0;
    found     = 1'b0;
    gone      = 0;
    case (it.kind)
      KIND_HELLO: begin
        if (it.serial != '0) begin
          for (i = 0; i < ENTRIES; i++) begin
            if (!found) begin
              if (nbr_serial[i] == it.serial) begin
                nbr_stamp[i] = it.now;
                found = 1'b1;
              end else if (nbr_serial[i] == '0) begin
                slot = i;
                have_free = 1'b1;
              end
            end
          end
          if (found) begin
            r.hit = 1'b1;
          end else if (have_free) begin
            nbr_serial[slot] = it.serial;
            nbr_stamp[slot]  = it.now;
            nbr_count++;
            r.inserted = 1'b1;
          end else begin
            r.dropped = 1'b1;
          end
        end
      end
      KIND_AGE: begin
        for (i = 0; i < ENTRIES; i++) begin
          if (nbr_serial[i] != '0) begin
            age = it.now - nbr_stamp[i];
            if (age >= max_age_cfg) begin
              nbr_serial[i] = '0;
              gone++;
            end
          end
        end
        nbr_count -= gone;
      end
      KIND_CLEAR: begin
        for (i = 0; i < ENTRIES; i++) begin
          if (nbr_serial[i] != '0) begin
            nbr_serial[i] = '0;
            gone++;
          end
        end
        nbr_count = 0;
      end
      default: ;
    endcase
    r.valid_count = nbr_count[OUT_CNT_W-1:0];
    r.removed     = gone[OUT_CNT_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // input transfers feed the predictor, output transfers are checked
  always @(posedge clk_i) begin
    hello_item_t   it;
    table_status_t exp_s;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        it.kind   = in_if.kind;
        it.serial = in_if.serial;
        it.now    = in_if.now;
        expected_status.push_back(update_table(it));
        in_taken = 1'b1;
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_status.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count++;
        end else begin
          exp_s = expected_status.pop_front();
          check_field("valid_count", exp_s.valid_count, out_if.valid_count);
          check_field("hit", exp_s.hit, out_if.hit);
          check_field("inserted", exp_s.inserted, out_if.inserted);
          check_field("dropped", exp_s.dropped, out_if.dropped);
          check_field("removed", exp_s.removed, out_if.removed);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    hello_item_t it;
    if (rst_ni) begin
      if (!in_if.valid || in_taken) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          it = pending_items.pop_front();
          in_if.valid  <= 1'b1;
          in_if.kind   <= it.kind;
          in_if.serial <= it.serial;
          in_if.now    <= it.now;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      in_taken = 1'b0;
      out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic push_item(input kind_e k, input logic [SERIAL_W-1:0] s,
                           input logic [STAMP_W-1:0] t);
    hello_item_t it;
    it.kind   = k;
    it.serial = s;
    it.now    = t;
    pending_items.push_back(it);
  endtask

  task automatic write_max_age(input logic [STAMP_W-1:0] v);
    @(negedge clk_i);
    max_age_we_i <= 1'b1;
    max_age_i    <= v;
    @(negedge clk_i);
    max_age_we_i <= 1'b0;
    max_age_cfg  = v;
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_if.valid || expected_status.size() != 0)
      @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // mostly a small pool of serials on a slowly moving clock, so that the
  // table fills, ages out and drops; the rest is noise on every bit
  task automatic push_random_item();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      push_item(KIND_HELLO, serial_pool[$urandom_range(0, 23)], stim_now);
      stim_now += STAMP_W'($urandom_range(0, 3));
    end else if (r < 62) begin
      push_item(KIND_HELLO, $urandom, STAMP_W'($urandom));
    end else if (r < 64) begin
      push_item(KIND_HELLO, '0, STAMP_W'($urandom));
    end else if (r < 78) begin
      if ($urandom_range(0, 9) == 0)
        push_item(KIND_AGE, $urandom, STAMP_W'($urandom));
      else
        push_item(KIND_AGE, $urandom, stim_now);
    end else if (r < 82) begin
      push_item(KIND_CLEAR, $urandom, STAMP_W'($urandom));
    end else begin
      push_item(KIND_STATUS, $urandom, STAMP_W'($urandom));
    end
  endtask

  initial begin
    int p;
    int n;
    rst_ni         = 1'b0;
    max_age_we_i   = 1'b0;
    max_age_i      = '0;
    in_if.valid    = 1'b0;
    in_if.kind     = KIND_STATUS;
    in_if.serial   = '0;
    in_if.now      = '0;
    out_if.ready   = 1'b0;
    in_taken       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fail_count     = 0;
    nbr_count      = 0;
    max_age_cfg    = 16'd60;
    for (n = 0; n < ENTRIES; n++) begin
      nbr_serial[n] = '0;
      nbr_stamp[n]  = '0;
    end
    for (n = 0; n < 24; n++) begin
      serial_pool[n] = $urandom;
      if (serial_pool[n] == '0) serial_pool[n] = n + 1;
    end
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    write_max_age(16'd60);
    push_item(KIND_STATUS, '0, '0);
    push_item(KIND_HELLO, '0, '0);
    push_item(KIND_HELLO, 32'hFFFF_FFFF, 16'hFFFF);
    push_item(KIND_HELLO, 32'h0000_0001, 16'h0000);
    push_item(KIND_HELLO, 32'hFFFF_FFFF, 16'h0005);
    push_item(KIND_AGE, '0, 16'h0030);
    // age of exactly max_age goes, one five seconds younger stays
    push_item(KIND_AGE, '0, 16'h003C);
    for (n = 0; n < 15; n++)
      push_item(KIND_HELLO, 32'h8000_0000 | (n << 4), 16'h0040);
    push_item(KIND_HELLO, 32'h1234_5678, 16'h0041);
    push_item(KIND_HELLO, 32'hFFFF_FFFF, 16'h0042);
    push_item(KIND_AGE, 32'hFFFF_FFFF, 16'h0050);
    push_item(KIND_CLEAR, 32'hFFFF_FFFF, 16'hFFFF);
    push_item(KIND_STATUS, 32'hFFFF_FFFF, 16'hFFFF);
    wait_drained();

    for (p = 0; p < 6; p++) begin
      case (p)
        0: begin write_max_age(16'd60); send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin write_max_age(16'd1); send_idle_pct = 67; recv_stall_pct = 0; end
        2: begin write_max_age(16'hFFFF); send_idle_pct = 0; recv_stall_pct = 67; end
        3: begin
          write_max_age(STAMP_W'($urandom_range(2, 500)));
          send_idle_pct  = 7;
          recv_stall_pct = 7;
        end
        4: begin write_max_age(16'd0); send_idle_pct = 0; recv_stall_pct = 0; end
        default: begin
          write_max_age(STAMP_W'($urandom_range(1, 65535)));
          send_idle_pct  = 0;
          recv_stall_pct = 67;
        end
      endcase
      stim_now = STAMP_W'($urandom);
      for (n = 0; n < 185; n++) push_random_item();
      wait_drained();
    end

    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[aging_neighbor_table_core] OK");
    end else begin
      $display("[aging_neighbor_table_core] ERROR");
    end
    $finish;
  end

endmodule
